// ----- sv/irfe_pkg.sv -----
// Package for the IR remote frame encoder.
// Holds payload structs, protocol codes, timing constants and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package irfe_pkg;

  localparam int GapW   = 20;
  localparam int SecW   = 13;
  localparam int IdxW   = 6;

  localparam logic [1:0] PROTO_NEC = 2'd0;
  localparam logic [1:0] PROTO_RC5 = 2'd1;
  localparam logic [1:0] PROTO_RCA = 2'd2;

  localparam logic [GapW-1:0] GAP_RESET = 20'd100000;
  localparam logic [GapW-1:0] GAP_MAX   = 20'd1000000;

  localparam logic [GapW-1:0] NEC_LEAD_ON  = 20'd9000;
  localparam logic [SecW-1:0] NEC_LEAD_OFF = 13'd4500;
  localparam logic [GapW-1:0] RCA_LEAD_ON  = 20'd4000;
  localparam logic [SecW-1:0] RCA_LEAD_OFF = 13'd4000;
  localparam logic [GapW-1:0] MARK_US      = 20'd500;
  localparam logic [SecW-1:0] NEC_SP0      = 13'd500;
  localparam logic [SecW-1:0] NEC_SP1      = 13'd1620;
  localparam logic [SecW-1:0] RCA_SP0      = 13'd1000;
  localparam logic [SecW-1:0] RCA_SP1      = 13'd2000;
  localparam logic [GapW-1:0] RC5_HALF_A   = 20'd830;
  localparam logic [SecW-1:0] RC5_HALF_B   = 13'd830;

  // index of the gap symbol: leader(s) + data bits
  localparam logic [IdxW-1:0] NEC_LAST_IDX = 6'd33;
  localparam logic [IdxW-1:0] RC5_LAST_IDX = 6'd18;
  localparam logic [IdxW-1:0] RCA_LAST_IDX = 6'd25;
  localparam logic [IdxW-1:0] RC5_FIRST_BIT = 6'd2;
  localparam logic [IdxW-1:0] PD_FIRST_BIT  = 6'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] code;
  } in_item_t;

  typedef struct packed {
    logic            first_level;
    logic [GapW-1:0] first_us;
    logic [SecW-1:0] second_us;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic            load;
    logic            emit;
    logic [IdxW-1:0] sym_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic            req_empty;
    logic            out_free;
    logic [IdxW-1:0] last_idx;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/irfe_ctrl.sv -----
// Controller for the IR remote frame encoder.
// Accepts a request, then steps the symbol index once per free output slot.
// Depends on irfe_pkg.
`default_nettype none
module irfe_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  irfe_pkg::dp_status_t  status,
  output irfe_pkg::dp_cmd_t     cmd
);
  import irfe_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic            state, state_next;
  logic [IdxW-1:0] idx, idx_next;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cmd.load    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.sym_idx = idx;
    in_stall    = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          idx_next = '0;
          if (!status.req_empty) begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          idx_next = idx + 1'b1;
          if (idx == status.last_idx) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/irfe_dp.sv -----
// Datapath for the IR remote frame encoder.
// Gap register, request latch with bit shifter, symbol builder, output register.
// Depends on irfe_pkg.
`default_nettype none
module irfe_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_wen,
  input  wire [19:0]            cfg_wdata,
  input  irfe_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output irfe_pkg::out_item_t   out_data,
  input  irfe_pkg::dp_cmd_t     cmd,
  output irfe_pkg::dp_status_t  status
);
  import irfe_pkg::*;

  logic [GapW-1:0] gap_us;
  logic [GapW-1:0] gap_sat;
  logic [1:0]      proto;
  logic [31:0]     sh, sh_load;
  logic            lvl;
  logic            bit_cur;
  logic            is_bit;
  logic            is_gap;
  logic            is_lead;
  logic            req_empty;
  logic [IdxW-1:0] last_idx;
  out_item_t       sym;

  always_comb begin
    case (in_data.cmd)
      PROTO_NEC: begin
        req_empty = (in_data.code == 32'd0);
        sh_load   = in_data.code;
      end
      PROTO_RC5: begin
        req_empty = (in_data.code[15:0] == 16'd0);
        sh_load   = {16'd0, in_data.code[15:0]};
      end
      PROTO_RCA: begin
        req_empty = (in_data.code[23:0] == 24'd0);
        sh_load   = {in_data.code[23:0], 8'd0};
      end
      default: begin
        req_empty = 1'b1;
        sh_load   = in_data.code;
      end
    endcase
  end

  always_comb begin
    case (proto)
      PROTO_RC5: last_idx = RC5_LAST_IDX;
      PROTO_RCA: last_idx = RCA_LAST_IDX;
      default:   last_idx = NEC_LAST_IDX;
    endcase
  end

  assign status = '{req_empty: req_empty,
                    out_free:  (!out_valid || !out_stall),
                    last_idx:  last_idx};

  assign gap_sat = (gap_us > GAP_MAX) ? GAP_MAX : gap_us;
  assign is_gap  = (cmd.sym_idx == last_idx);
  assign is_lead = (proto == PROTO_RC5) ? (cmd.sym_idx < RC5_FIRST_BIT)
                                        : (cmd.sym_idx < PD_FIRST_BIT);
  assign is_bit  = !is_gap && !is_lead;
  assign bit_cur = (proto == PROTO_RC5) ? sh[0] : sh[31];

  always_comb begin
    sym.last        = 1'b0;
    sym.first_level = 1'b1;
    sym.first_us    = MARK_US;
    sym.second_us   = NEC_SP0;
    if (is_gap) begin
      sym.first_level = (proto == PROTO_RC5) ? ~lvl : 1'b0;
      sym.first_us    = gap_sat;
      sym.second_us   = '0;
      sym.last        = 1'b1;
    end else if (is_lead) begin
      case (proto)
        PROTO_RC5: begin
          sym.first_level = 1'b0;
          sym.first_us    = RC5_HALF_A;
          sym.second_us   = RC5_HALF_B;
        end
        PROTO_RCA: begin
          sym.first_us  = RCA_LEAD_ON;
          sym.second_us = RCA_LEAD_OFF;
        end
        default: begin
          sym.first_us  = NEC_LEAD_ON;
          sym.second_us = NEC_LEAD_OFF;
        end
      endcase
    end else begin
      case (proto)
        PROTO_RC5: begin
          sym.first_level = ~bit_cur;
          sym.first_us    = RC5_HALF_A;
          sym.second_us   = RC5_HALF_B;
        end
        PROTO_RCA: begin
          sym.second_us = bit_cur ? RCA_SP1 : RCA_SP0;
        end
        default: begin
          sym.second_us = bit_cur ? NEC_SP1 : NEC_SP0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_us    <= GAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        gap_us <= cfg_wdata;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      proto <= in_data.cmd;
      sh    <= sh_load;
      lvl   <= 1'b0;
    end else if (cmd.emit && is_bit) begin
      lvl <= ~bit_cur;
      if (proto == PROTO_RC5) begin
        sh <= {1'b0, sh[31:1]};
      end else begin
        sh <= {sh[30:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      out_data <= sym;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ir_remote_frame_encoder.sv -----
// IR remote frame encoder, NEC / RC5-style / RCA.
// A frame request (protocol, code word) on the input channel becomes a run of
// symbols on the output channel: first level, first and second duration in us.
// Input: in_valid / in_stall / in_data. Output: out_valid / out_stall / out_data.
// Both channels move an item on a clock edge with valid high and stall low.
// cfg_wen / cfg_wdata write the inter-frame gap in us (reset 100000, capped at
// 1000000 on use); write it only while no frame is in flight.
// Each accepted request is latched; the controller then emits its symbols
// through a single output register, one symbol per cycle while the output
// register is free. A frame has 34 (NEC), 19 (RC5) or 26 (RCA) symbols, stepped
// by the symbol index counter in the controller; a new request is accepted only
// after the previous frame's last symbol has been emitted. in_stall stays high
// while a frame is running. A request whose used code bits are zero, or an unused
// protocol code, is accepted and produces nothing.
// When out_stall is high a valid output item holds and the controller waits.
// Reset (rst, synchronous) drops out_valid, idles the controller, restores gap.
// Depends on irfe_pkg, irfe_ctrl, irfe_dp.
`default_nettype none
module ir_remote_frame_encoder (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wen,
  input  wire [19:0]           cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  irfe_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output irfe_pkg::out_item_t  out_data
);
  import irfe_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  irfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  irfe_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ir_remote_frame_encoder: drives frame requests,
// predicts every symbol of each frame and checks the output item stream.
// Depends on irfe_pkg and the encoder RTL.
module tb;
  import irfe_pkg::*;

  localparam int unsigned GapCap = 1000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wen = 1'b0;
  logic [19:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  req_queue[$];
  out_item_t sym_expect[$];
  logic [19:0] gap_shadow = 20'd100000;
  logic      req_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned failures = 0;
  int unsigned reqs_taken = 0;
  int unsigned frames_seen = 0;
  int unsigned syms_checked = 0;

  ir_remote_frame_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic void push_sym(logic lvl, logic [19:0] a, logic [12:0] b, logic fin);
    out_item_t s;
    s.first_level = lvl;
    s.first_us = a;
    s.second_us = b;
    s.last = fin;
    sym_expect.push_back(s);
  endfunction

  function automatic logic [19:0] gap_len();
    return (gap_shadow > GapCap) ? 20'(GapCap) : gap_shadow;
  endfunction

  function automatic void pulse_distance(logic [31:0] word, int nbits, logic [19:0] lead_on,
                                         logic [12:0] lead_off, logic [12:0] sp0,
                                         logic [12:0] sp1);
    push_sym(1'b1, lead_on, lead_off, 1'b0);
    for (int i = nbits - 1; i >= 0; i--) begin
      push_sym(1'b1, 20'd500, word[i] ? sp1 : sp0, 1'b0);
    end
    push_sym(1'b0, gap_len(), 13'd0, 1'b1);
  endfunction

  function automatic void encode_frame(in_item_t req);
    logic lvl;
    lvl = 1'b0;
    case (req.cmd)
      PROTO_NEC: begin
        if (req.code != 32'd0) begin
          pulse_distance(req.code, 32, 20'd9000, 13'd4500, 13'd500, 13'd1620);
          frames_seen++;
        end
      end
      PROTO_RC5: begin
        if (req.code[15:0] != 16'd0) begin
          push_sym(1'b0, 20'd830, 13'd830, 1'b0);
          push_sym(1'b0, 20'd830, 13'd830, 1'b0);
          for (int i = 0; i < 16; i++) begin
            lvl = ~req.code[i];
            push_sym(lvl, 20'd830, 13'd830, 1'b0);
          end
          push_sym(~lvl, gap_len(), 13'd0, 1'b1);
          frames_seen++;
        end
      end
      PROTO_RCA: begin
        if (req.code[23:0] != 24'd0) begin
          pulse_distance({8'd0, req.code[23:0]}, 24, 20'd4000, 13'd4000, 13'd1000, 13'd2000);
          frames_seen++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t rand_request();
    in_item_t r;
    int unsigned pick;
    r.cmd = ($urandom_range(99) < 6) ? 2'd3 : 2'($urandom_range(2));
    pick = $urandom_range(9);
    if (pick == 0) begin
      r.code = $urandom;
      case (r.cmd)
        PROTO_NEC: r.code = '0;
        PROTO_RC5: r.code[15:0] = '0;
        PROTO_RCA: r.code[23:0] = '0;
        default: ;
      endcase
    end else if (pick == 1) begin
      r.code = 32'd1 << $urandom_range(31);
    end else begin
      r.code = $urandom;
    end
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] c, logic [31:0] w);
    in_item_t r;
    r.cmd = c;
    r.code = w;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (!rst && req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= req_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor, scoreboard
  always @(posedge clk) begin
    req_taken = 1'b0;
    if (!rst) begin
      if (cfg_wen) gap_shadow = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (sym_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: symbol with no pending expectation: %p", $realtime, out_data);
        end else begin
          out_item_t e;
          e = sym_expect.pop_front();
          syms_checked++;
          if (out_data.first_level !== e.first_level || out_data.first_us !== e.first_us ||
              out_data.second_us !== e.second_us || out_data.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: symbol mismatch exp lvl=%0b a=%0d b=%0d last=%0b got lvl=%0b a=%0d b=%0d last=%0b",
                       $realtime, e.first_level, e.first_us, e.second_us, e.last,
                       out_data.first_level, out_data.first_us, out_data.second_us,
                       out_data.last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        req_taken = 1'b1;
        reqs_taken++;
        encode_frame(in_data);
      end
    end
  end

  task automatic drain();
    while (req_queue.size() > 0 || in_valid || sym_expect.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_gap(logic [19:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic random_phase(logic [19:0] g, int unsigned idle, int unsigned stall, int n);
    drain();
    write_gap(g);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) req_queue.push_back(rand_request());
  endtask

  initial begin
    int unsigned wait_cycles;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, both bit orders, ignored bits, empty requests
    req_queue.push_back(mk(PROTO_NEC, 32'hFFFF_FFFF));
    req_queue.push_back(mk(PROTO_NEC, 32'h0000_0001));
    req_queue.push_back(mk(PROTO_NEC, 32'h8000_0000));
    req_queue.push_back(mk(PROTO_NEC, 32'h0000_0000));
    req_queue.push_back(mk(PROTO_NEC, 32'hA5A5_5A5A));
    req_queue.push_back(mk(PROTO_RC5, 32'h0000_FFFF));
    req_queue.push_back(mk(PROTO_RC5, 32'h0000_0001));
    req_queue.push_back(mk(PROTO_RC5, 32'h0000_8000));
    req_queue.push_back(mk(PROTO_RC5, 32'hFFFF_0000));
    req_queue.push_back(mk(PROTO_RC5, 32'h1234_AA55));
    req_queue.push_back(mk(PROTO_RCA, 32'h00FF_FFFF));
    req_queue.push_back(mk(PROTO_RCA, 32'h0000_0001));
    req_queue.push_back(mk(PROTO_RCA, 32'h0080_0000));
    req_queue.push_back(mk(PROTO_RCA, 32'hFF00_0000));
    req_queue.push_back(mk(PROTO_RCA, 32'hC35A_5AC3));
    req_queue.push_back(mk(2'd3, 32'hFFFF_FFFF));
    req_queue.push_back(mk(2'd3, 32'h0000_0000));

    random_phase(20'd0, 0, 0, 114);
    random_phase(20'd1000000, 49, 0, 114);
    random_phase(20'hFFFFF, 0, 49, 114);
    random_phase(20'($urandom_range(1048575)), 36, 36, 114);

    while (req_queue.size() > 0 || in_valid) @(posedge clk);
    wait_cycles = 0;
    while (sym_expect.size() > 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (sym_expect.size() > 0) begin
      failures += sym_expect.size();
      $display("%0d expected symbols never arrived", sym_expect.size());
    end

    $display("Sent %0d requests (%0d frames, rest empty or ignored), checked %0d symbols.",
             reqs_taken, frames_seen, syms_checked);
    $display("Gap settings: reset, zero, max, oversized, random; idle/stall mixes 0-49%%.");
    if (failures == 0 && mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d other failures", mismatches, failures);
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/irfe_pkg.sv
sv/irfe_ctrl.sv
sv/irfe_dp.sv
sv/ir_remote_frame_encoder.sv
sim/tb.sv
